@@ rtl/assert_macros.svh @@
// Assertion macros included by the receiver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/fmr_pkg.sv @@
// Constants and types of the FSK Manchester RFID receiver.
package fmr_pkg;

    // Payload length in decoded bits and width of the reported frame.
    localparam int PAYLOAD_BITS = 44;
    localparam int FRAME_BITS   = 44;

    localparam int TIME_W  = 32;
    localparam int TICKS_W = 24;
    localparam int RUN_W   = 3;
    localparam int COUNT_W = 8;
    localparam int HIST_W  = 8;

    typedef logic [TIME_W-1:0]       t_time;
    typedef logic [TICKS_W-1:0]      t_ticks;
    typedef logic [RUN_W-1:0]        t_run;
    typedef logic [COUNT_W-1:0]      t_count;
    typedef logic [HIST_W-1:0]       t_hist;
    typedef logic [PAYLOAD_BITS-1:0] t_payload;
    typedef logic [FRAME_BITS-1:0]   t_frame;

    // Reset value of the long pulse threshold: 72 us at 64 MHz.
    localparam t_ticks LONG_TICKS_RESET = t_ticks'(4608);

    // Preamble 0,0,0,1,1,1,0,1 with the oldest symbol in bit 0.
    localparam t_hist PREAMBLE = 8'hB8;

    // Last run counter value before it wraps to zero.
    localparam t_run RUN_LAST = t_run'(5);
    // Run counter value at which the symbol of a run is taken.
    localparam t_run RUN_SAMPLE = t_run'(1);

    // Symbol counter limits.
    localparam t_count COUNT_MAX       = t_count'(250);
    localparam t_count SEARCH_MIN      = t_count'(8);
    localparam t_count FRAME_END_COUNT = t_count'(2 * PAYLOAD_BITS);
    localparam t_count REOPEN_COUNT    = t_count'(8);

endpackage

@@ rtl/fsk_manchester_rfid_receiver.sv @@
// Top level of the FSK Manchester RFID receiver: pulse timing, symbol and frame decode.
//
// Usage:
// The input channel (i_in_valid, o_in_ready, i_edge_time) takes one word per
// carrier edge: the free-running tick timestamp of that edge. The output
// channel (o_out_valid, i_out_ready) returns one word per input word with
// o_frame_valid, o_frame_bits and o_in_frame. o_frame_bits holds the decoded
// payload, first received bit in the MSB, when o_frame_valid is high, else 0.
// The threshold register is written through i_cfg_wr_en and i_cfg_wr_data; the user
// must write it only while the block is idle, which the block does not enforce. A
// pulse is long when the edge spacing exceeds it. A word accepted at one edge shows
// its result at the output register after that edge. Throughput is one word per
// cycle while the consumer keeps up; the whole per-edge decode is a single subtract
// and compare plus small control logic ahead of the result register.
// A synchronous active-low reset clears all decoder state, empties the
// output register and restores the threshold to 4608 ticks.
// When the consumer stalls, the result word holds and o_in_ready drops, so
// no new edge is taken until the result has been taken or is taken in the
// same cycle.
module fsk_manchester_rfid_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [fmr_pkg::TICKS_W-1:0]    i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [fmr_pkg::TIME_W-1:0]     i_edge_time,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_frame_valid,
    output logic [fmr_pkg::FRAME_BITS-1:0] o_frame_bits,
    output logic                           o_in_frame
);

    // Decoder state.
    fmr_pkg::t_ticks   r_long_ticks;
    fmr_pkg::t_time    r_prev_time;
    logic              r_prev_long;
    fmr_pkg::t_run     r_run;
    fmr_pkg::t_count   r_count;
    logic              r_collecting;
    logic              r_first_half;
    fmr_pkg::t_hist    r_hist;
    fmr_pkg::t_payload r_payload;

    // Output register.
    logic              r_out_valid;
    logic              r_frame_valid;
    fmr_pkg::t_frame   r_frame_bits;
    logic              r_in_frame;

    // Next values.
    fmr_pkg::t_run     n_run;
    fmr_pkg::t_count   n_count;
    logic              n_collecting;
    logic              n_first_half;
    fmr_pkg::t_hist    n_hist;
    fmr_pkg::t_payload n_payload;
    logic              n_done;

    // Working signals.
    fmr_pkg::t_time    w_delta;
    logic              w_pulse;
    logic              w_take;
    logic [2:0]        w_rot;
    logic [15:0]       w_hist_rot;
    logic              w_match;
    fmr_pkg::t_count   w_count_mid;
    fmr_pkg::t_count   w_count_inc;
    logic              w_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Pulse classification and run counting.
    always_comb begin
        w_delta = i_edge_time - r_prev_time;
        w_pulse = (w_delta > {{(fmr_pkg::TIME_W - fmr_pkg::TICKS_W){1'b0}}, r_long_ticks});
        w_take  = 1'b0;
        if (w_pulse == r_prev_long) begin
            w_take = (r_run == fmr_pkg::RUN_SAMPLE);
            n_run  = (r_run == fmr_pkg::RUN_LAST) ? '0 : r_run + fmr_pkg::t_run'(1);
        end else begin
            n_run = '0;
        end
    end

    // Symbol history write and preamble match over the updated history.
    always_comb begin
        n_hist = r_hist;
        if (w_take && !r_collecting) begin
            n_hist[r_count[2:0]] = w_pulse;
        end
        w_rot      = r_count[2:0] + 3'd1;
        w_hist_rot = {n_hist, n_hist} >> w_rot;
        w_match    = (w_hist_rot[7:0] == fmr_pkg::PREAMBLE);
    end

    // Preamble detection, Manchester pair decode and frame end.
    always_comb begin
        n_collecting = r_collecting;
        n_first_half = r_first_half;
        n_payload    = r_payload;
        n_done       = 1'b0;
        w_count_mid  = r_count;
        if (w_take) begin
            if (!r_collecting) begin
                if (r_count > fmr_pkg::SEARCH_MIN && w_match) begin
                    n_collecting = 1'b1;
                    w_count_mid  = '0;
                    n_first_half = w_pulse;
                    n_payload    = '0;
                end
            end else begin
                if (!r_count[0]) begin
                    if (!r_first_half && w_pulse) begin
                        n_payload = fmr_pkg::PAYLOAD_BITS'({r_payload, 1'b0});
                    end else if (r_first_half && !w_pulse) begin
                        n_payload = fmr_pkg::PAYLOAD_BITS'({r_payload, 1'b1});
                    end else begin
                        n_collecting = 1'b0;
                    end
                end else begin
                    n_first_half = w_pulse;
                end
                if (r_count == fmr_pkg::FRAME_END_COUNT) begin
                    n_done       = n_collecting;
                    w_count_mid  = fmr_pkg::REOPEN_COUNT;
                    n_collecting = 1'b0;
                end
            end
        end
        w_count_inc = w_count_mid + fmr_pkg::t_count'(1);
        if (!w_take) begin
            n_count = r_count;
        end else if (w_count_inc > fmr_pkg::COUNT_MAX) begin
            n_count = '0;
        end else begin
            n_count = w_count_inc;
        end
    end

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks <= fmr_pkg::LONG_TICKS_RESET;
        end else if (i_cfg_wr_en) begin
            r_long_ticks <= i_cfg_wr_data;
        end
    end

    // Decoder state advances on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time  <= '0;
            r_prev_long  <= 1'b0;
            r_run        <= '0;
            r_count      <= '0;
            r_collecting <= 1'b0;
            r_first_half <= 1'b0;
            r_hist       <= '0;
            r_payload    <= '0;
        end else if (w_accept) begin
            r_prev_time  <= i_edge_time;
            r_prev_long  <= w_pulse;
            r_run        <= n_run;
            r_count      <= n_count;
            r_collecting <= n_collecting;
            r_first_half <= n_first_half;
            r_hist       <= n_hist;
            r_payload    <= n_payload;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_frame_valid <= n_done;
            r_frame_bits  <= n_done ? fmr_pkg::FRAME_BITS'(n_payload) : '0;
            r_in_frame    <= n_collecting;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_valid = r_frame_valid;
    assign o_frame_bits  = r_frame_bits;
    assign o_in_frame    = r_in_frame;

    // Assertions.
    `include "assert_macros.svh"

    `ASSERT_IMPLIES(a_done_closes_frame, r_out_valid && r_frame_valid, !r_in_frame, "frame reported while still collecting")
    `ASSERT_IMPLIES(a_collect_count, r_collecting, (r_count != '0) && (r_count <= fmr_pkg::FRAME_END_COUNT), "symbol count out of range during collection")
    `ASSERT_IMPLIES(a_run_range, 1'b1, r_run <= fmr_pkg::RUN_LAST, "run counter past its wrap point")
    `ASSERT_NEXT(a_idle_state_holds, !w_accept, $stable(r_count) && $stable(r_payload), "decoder state changed without an accepted word")

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the FSK Manchester RFID receiver, with its own decoder predictor.
module tb;

    typedef struct packed {
        logic             frame_valid;
        fmr_pkg::t_frame  frame_bits;
        logic             in_frame;
    } t_frame_result;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;
    typedef enum int {FAULT_NONE, FAULT_LAST_PAIR, FAULT_EARLY} t_frame_fault;

    localparam int IDLE_PCT     = 69;
    localparam int BOTH_PCT     = 6;
    localparam int MODE_SPAN    = 97;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 48;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_wr_en = 1'b0;
    fmr_pkg::t_ticks i_cfg_wr_data = '0;
    logic            i_in_valid = 1'b0;
    logic            o_in_ready;
    fmr_pkg::t_time  i_edge_time = '0;
    logic            o_out_valid;
    logic            i_out_ready = 1'b0;
    logic            o_frame_valid;
    fmr_pkg::t_frame o_frame_bits;
    logic            o_in_frame;

    fsk_manchester_rfid_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_edge_time   (i_edge_time),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_frame_valid (o_frame_valid),
        .o_frame_bits  (o_frame_bits),
        .o_in_frame    (o_in_frame)
    );

    // Edge timestamps waiting to be sent, and decoded results waiting to be seen.
    fmr_pkg::t_time edge_queue[$];
    t_frame_result  expected_results[$];
    int             words_in_flight = 0;
    int             accepted_words = 0;
    int             failures = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;

    // Decoder state as the predictor sees it; initial values match reset.
    fmr_pkg::t_ticks   m_threshold = fmr_pkg::LONG_TICKS_RESET;
    fmr_pkg::t_time    m_prev_time = '0;
    logic              m_prev_long = 1'b0;
    fmr_pkg::t_run     m_run = '0;
    fmr_pkg::t_count   m_symbols = '0;
    logic              m_collecting = 1'b0;
    logic              m_first_half = 1'b0;
    fmr_pkg::t_hist    m_history = '0;
    fmr_pkg::t_payload m_shift = '0;

    // Generator view of the line, used to shape pulses for the current threshold.
    fmr_pkg::t_ticks gen_thr = fmr_pkg::LONG_TICKS_RESET;
    fmr_pkg::t_time  gen_time = '0;
    logic            gen_long = 1'b0;
    logic            sym_q[$];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The last eight symbols, oldest first, against the preamble.
    function automatic logic preamble_seen();
        logic       hit;
        logic [2:0] slot;
        hit = 1'b1;
        for (int i = 0; i < 8; i++) begin
            slot = m_symbols[2:0] + 3'(i + 1);
            if (m_history[slot] != fmr_pkg::PREAMBLE[i]) hit = 1'b0;
        end
        return hit;
    endfunction

    // One symbol into the preamble search or the Manchester pair decoder.
    function automatic logic take_symbol(input logic sym);
        logic done;
        done = 1'b0;
        if (!m_collecting) begin
            m_history[m_symbols[2:0]] = sym;
            if (m_symbols > fmr_pkg::SEARCH_MIN && preamble_seen()) begin
                m_collecting = 1'b1;
                m_symbols = '0;
                m_first_half = sym;
                m_shift = '0;
            end
        end else begin
            if (!m_symbols[0]) begin
                if (!m_first_half && sym) begin
                    m_shift = {m_shift[fmr_pkg::PAYLOAD_BITS-2:0], 1'b0};
                end else if (m_first_half && !sym) begin
                    m_shift = {m_shift[fmr_pkg::PAYLOAD_BITS-2:0], 1'b1};
                end else begin
                    m_collecting = 1'b0;
                end
            end else begin
                m_first_half = sym;
            end
            if (m_symbols == fmr_pkg::FRAME_END_COUNT) begin
                done = m_collecting;
                m_symbols = fmr_pkg::REOPEN_COUNT;
                m_collecting = 1'b0;
            end
        end
        m_symbols = m_symbols + 1'b1;
        if (m_symbols > fmr_pkg::COUNT_MAX) m_symbols = '0;
        return done;
    endfunction

    // Classify the pulse ending at this edge and advance the decoder.
    function automatic t_frame_result predict_edge(input fmr_pkg::t_time t);
        t_frame_result res;
        logic          is_long;
        logic          done;
        is_long = (t - m_prev_time) > fmr_pkg::t_time'(m_threshold);
        done = 1'b0;
        m_prev_time = t;
        if (is_long == m_prev_long) begin
            if (m_run == fmr_pkg::RUN_SAMPLE) done = take_symbol(is_long);
            m_run = (m_run == fmr_pkg::RUN_LAST) ? '0 : m_run + 1'b1;
        end else begin
            m_run = '0;
        end
        m_prev_long = is_long;
        res.frame_valid = done;
        res.frame_bits = done ? fmr_pkg::t_frame'(m_shift) : '0;
        res.in_frame = m_collecting;
        return res;
    endfunction

    function automatic t_idle idle_mode();
        return t_idle'((accepted_words / MODE_SPAN) % 4);
    endfunction

    function automatic bit sender_idles();
        return (idle_mode() == IDLE_SENDER && $urandom_range(0, 99) < IDLE_PCT) ||
               (idle_mode() == IDLE_BOTH && $urandom_range(0, 99) < BOTH_PCT);
    endfunction

    function automatic bit receiver_stalls();
        return (idle_mode() == IDLE_RECEIVER && $urandom_range(0, 99) < IDLE_PCT) ||
               (idle_mode() == IDLE_BOTH && $urandom_range(0, 99) < BOTH_PCT);
    endfunction

    task automatic push_edge(input fmr_pkg::t_time t);
        gen_long = (t - gen_time) > fmr_pkg::t_time'(gen_thr);
        gen_time = t;
        edge_queue.push_back(t);
        words_in_flight++;
    endtask

    // One pulse of the given class, with the spacing often on a boundary.
    task automatic push_pulse(input logic lng);
        fmr_pkg::t_time dt;
        fmr_pkg::t_time thr;
        thr = fmr_pkg::t_time'(gen_thr);
        case ($urandom_range(0, 7))
            0: dt = lng ? thr + 1 : thr;
            1: dt = lng ? 32'hFFFF_FFFF : 32'h0;
            default: dt = lng ? thr + 1 + ($urandom % (32'hFFFF_FFFF - thr))
                              : $urandom_range(thr, 0);
        endcase
        push_edge(gen_time + dt);
    endtask

    // A run of equal pulses carrying m equal symbols; the first pulse always changes class.
    task automatic push_group(input logic sym, input int m);
        int extra;
        extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
        if (sym == gen_long) push_pulse(!sym);
        repeat (3 + 6 * (m - 1) + extra) push_pulse(sym);
    endtask

    task automatic flush_symbols();
        int i;
        int m;
        i = 0;
        while (i < sym_q.size()) begin
            m = 1;
            while (i + m < sym_q.size() && sym_q[i + m] == sym_q[i]) m++;
            push_group(sym_q[i], m);
            i += m;
        end
        sym_q.delete();
    endtask

    // Random symbols that never hold three zeros in a row, so they cannot form the preamble.
    task automatic add_noise(input int n);
        logic s;
        repeat (n) begin
            s = 1'($urandom_range(0, 1));
            if (sym_q.size() >= 2 && !sym_q[sym_q.size() - 1] && !sym_q[sym_q.size() - 2])
                s = 1'b1;
            sym_q.push_back(s);
        end
    endtask

    // Noise, preamble, Manchester pairs with an optional broken pair, trailing noise.
    // An early broken pair ends the Manchester pairs right after that pair.
    task automatic push_frame_sequence(input t_frame_fault fault);
        fmr_pkg::t_payload card;
        int                bad_pair;
        int                pairs;
        logic              b;
        card = fmr_pkg::t_payload'({$urandom, $urandom});
        bad_pair = -1;
        pairs = fmr_pkg::PAYLOAD_BITS;
        if (fault == FAULT_LAST_PAIR) begin
            // A card of one repeated bit keeps the pulse count of this frame low.
            card = {fmr_pkg::PAYLOAD_BITS{card[0]}};
            bad_pair = fmr_pkg::PAYLOAD_BITS - 1;
        end else if (fault == FAULT_EARLY) begin
            bad_pair = $urandom_range(0, 7);
            pairs = bad_pair + 1;
        end
        repeat ($urandom_range(0, 1)) push_edge($urandom);
        add_noise($urandom_range(3, 5));
        for (int i = 0; i < 8; i++) sym_q.push_back(fmr_pkg::PREAMBLE[i]);
        for (int p = 0; p < pairs; p++) begin
            if (p == bad_pair) begin
                b = 1'($urandom_range(0, 1));
                sym_q.push_back(b);
                sym_q.push_back(b);
            end else begin
                b = card[fmr_pkg::PAYLOAD_BITS - 1 - p];
                sym_q.push_back(b);
                sym_q.push_back(!b);
            end
        end
        add_noise($urandom_range(0, 2));
        flush_symbols();
    endtask

    task automatic wait_for_drain();
        while (words_in_flight != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input fmr_pkg::t_ticks value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        m_threshold = value;
        gen_thr = value;
    endtask

    // Input side: predict on every accepted word, then offer the next one.
    always @(posedge i_clk) begin : word_driver
        logic accept;
        logic offer;
        accept = i_in_valid && o_in_ready;
        if (accept) begin
            expected_results.push_back(predict_edge(i_edge_time));
            accepted_words++;
        end
        if (i_rst_n && (accept || !i_in_valid)) begin
            offer = edge_queue.size() != 0 && !sender_idles();
            if (offer) i_edge_time <= edge_queue.pop_front();
            i_in_valid <= offer;
        end
    end

    // One long receiver hold-off while the sender keeps offering words.
    always @(posedge i_clk) begin : hold_off
        if (!hold_done && accepted_words >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output side: compare each result word with the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_frame_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word arrived with no prediction waiting");
                failures++;
            end else begin
                want = expected_results.pop_front();
                words_in_flight--;
                if (o_frame_valid !== want.frame_valid) begin
                    $error("frame_valid: expected %0b, got %0b", want.frame_valid, o_frame_valid);
                    failures++;
                end
                if (o_frame_bits !== want.frame_bits) begin
                    $error("frame_bits: expected %h, got %h", want.frame_bits, o_frame_bits);
                    failures++;
                end
                if (o_in_frame !== want.in_frame) begin
                    $error("in_frame: expected %0b, got %0b", want.in_frame, o_in_frame);
                    failures++;
                end
            end
        end
        i_out_ready <= (hold_left == 0) && !receiver_stalls();
    end

    // Stimulus phases, with a threshold change whenever the block has drained.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Threshold boundaries, zero and full-scale spacing, and a run long enough to wrap.
        push_edge(fmr_pkg::t_time'(fmr_pkg::LONG_TICKS_RESET));
        push_edge(fmr_pkg::t_time'(fmr_pkg::LONG_TICKS_RESET));
        push_edge(gen_time + fmr_pkg::t_time'(fmr_pkg::LONG_TICKS_RESET) + 1);
        repeat (10) push_pulse(1'b1);
        push_edge(gen_time - 1);
        push_edge(32'hFFFF_FFFF);
        push_edge(32'h0);
        push_edge(32'hFFFF_FFFF);
        push_edge(32'h8000_0000);
        repeat (4) push_pulse(1'b0);
        wait_for_drain();

        // Largest threshold with a clean frame.
        write_threshold(24'hFF_FFFF);
        push_frame_sequence(FAULT_NONE);
        wait_for_drain();

        // Zero threshold with a broken last pair, which must suppress the frame.
        write_threshold('0);
        push_frame_sequence(FAULT_LAST_PAIR);
        wait_for_drain();

        // Random threshold with a pair error early in the frame, then random edges.
        write_threshold(fmr_pkg::t_ticks'($urandom_range(1, 24'hFF_FFFE)));
        push_frame_sequence(FAULT_EARLY);
        repeat (6) push_edge($urandom);
        wait_for_drain();

        if (failures == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ fsk_manchester_rfid_receiver.f @@
+incdir+rtl
rtl/fmr_pkg.sv
rtl/fsk_manchester_rfid_receiver.sv
verif/tb.sv
